@@ design/lir_pkg.sv @@
// shared types and constants for the linear interpolation resampler
package lir_pkg;

    // default number of fraction bits in phase and step
    localparam int FRAC_BITS_DEF = 16;

    // sample width of one channel
    localparam int SAMPLE_W = 16;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATIO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYPASS     = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_L,
        ST_MUL_R,
        ST_FIN,
        ST_SEND
    } state_t;

endpackage

@@ design/linear_interp_resampler_core.sv @@
// linear interpolation sample rate converter with one shared multiplier
// a frame that interpolates passes CHECK, MUL_L, MUL_R and FIN before its first result in SEND
// each further result runs MUL_L, MUL_R, FIN on the shared 17-bit multiplier, then waits in SEND
// one frame gives up to 16 results, or none when the phase is at or above 1.0 in CHECK
// bypass frames and the first stored frame skip the multiplier; no frame is taken while one is in work
// reset: step 1.0, mono, no bypass, previous frame and phase cleared, no frame seen
module linear_interp_resampler_core #(
    parameter int FRAC_BITS = lir_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input frame channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [lir_pkg::SAMPLE_W-1:0] left_sample,
    input  logic signed [lir_pkg::SAMPLE_W-1:0] right_sample,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [lir_pkg::SAMPLE_W-1:0] out_left,
    output logic signed [lir_pkg::SAMPLE_W-1:0] out_right,
    output logic                              run_last,
    // configuration write port
    input  logic                              cfg_wen,
    input  logic [lir_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [FRAC_BITS+6:0]              cfg_data
);

    localparam int SW     = lir_pkg::SAMPLE_W;
    localparam int ST_W   = FRAC_BITS + 7;          // step register width
    localparam int PH_W   = FRAC_BITS + 8;          // phase accumulator width
    localparam int DIFF_W = SW + 1;                 // b - a
    localparam int PROD_W = DIFF_W + FRAC_BITS + 1; // (b - a) * frac, also the lerp numerator

    localparam logic [PH_W-1:0] ONE_FX   = PH_W'(1) << FRAC_BITS;
    localparam logic [ST_W-1:0] STEP_MIN = ST_W'(1) << (FRAC_BITS - 4);
    localparam logic [ST_W-1:0] STEP_MAX = ST_W'(1) << (FRAC_BITS + 6);
    localparam logic [ST_W-1:0] STEP_RST = ST_W'(1) << FRAC_BITS;

    // control state
    lir_pkg::state_t state_reg, state_next;
    logic [ST_W-1:0] step_ratio_reg, step_ratio_next;
    logic            stereo_reg, stereo_next;
    logic            bypass_reg, bypass_next;
    logic            have_prev_reg, have_prev_next;
    logic [PH_W-1:0] phase_reg, phase_next;
    logic            out_valid_reg, out_valid_next;
    logic            byp_run_reg, byp_run_next;     // current transaction is a bypass frame

    // payload
    logic signed [SW-1:0]     cur_l_reg, cur_l_next;
    logic signed [SW-1:0]     cur_r_reg, cur_r_next;
    logic signed [SW-1:0]     prev_l_reg, prev_l_next;
    logic signed [SW-1:0]     prev_r_reg, prev_r_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [SW-1:0]     out_left_reg, out_left_next;
    logic signed [SW-1:0]     out_right_reg, out_right_next;
    logic                     last_reg, last_next;

    // datapath
    logic [ST_W-1:0]            step_use;
    logic [PH_W-1:0]            phase_sum;
    logic signed [DIFF_W-1:0]   diff_s;
    logic signed [FRAC_BITS:0]  frac_s;
    logic signed [PROD_W-1:0]   prod;
    logic signed [SW-1:0]       a_sel;
    logic signed [PROD_W-1:0]   base_s;
    logic signed [PROD_W-1:0]   num;
    logic                       round_up;
    logic signed [SW-1:0]       lerp;

    // clamp the step to 1/16 .. 64 so one frame gives at most 16 results
    always_comb
    begin
        priority if (step_ratio_reg < STEP_MIN)
        begin
            step_use = STEP_MIN;
        end
        else if (step_ratio_reg > STEP_MAX)
        begin
            step_use = STEP_MAX;
        end
        else
        begin
            step_use = step_ratio_reg;
        end
    end

    assign phase_sum = phase_reg + PH_W'(step_use);

    // shared multiplier: left difference in MUL_L, right difference in MUL_R
    always_comb
    begin
        if (state_reg == lir_pkg::ST_MUL_L)
        begin
            diff_s = DIFF_W'(cur_l_reg) - DIFF_W'(prev_l_reg);
        end
        else
        begin
            diff_s = DIFF_W'(cur_r_reg) - DIFF_W'(prev_r_reg);
        end
    end

    // phase is below 1.0 whenever the multiplier is in use
    assign frac_s = signed'({1'b0, phase_reg[FRAC_BITS-1:0]});
    assign prod   = PROD_W'(diff_s) * PROD_W'(frac_s);

    // shared adder: a * 1.0 + product, then divide by 1.0 rounding toward zero
    assign a_sel    = (state_reg == lir_pkg::ST_MUL_R) ? prev_l_reg : prev_r_reg;
    assign base_s   = PROD_W'(signed'({a_sel, {FRAC_BITS{1'b0}}}));
    assign num      = base_s + prod_reg;
    assign round_up = num[PROD_W-1] & (|num[FRAC_BITS-1:0]);
    assign lerp     = SW'(num[PROD_W-1:FRAC_BITS]) + SW'(round_up);

    // sequencer and register next values
    always_comb
    begin
        state_next      = state_reg;
        step_ratio_next = step_ratio_reg;
        stereo_next     = stereo_reg;
        bypass_next     = bypass_reg;
        have_prev_next  = have_prev_reg;
        phase_next      = phase_reg;
        out_valid_next  = out_valid_reg;
        byp_run_next    = byp_run_reg;
        cur_l_next      = cur_l_reg;
        cur_r_next      = cur_r_reg;
        prev_l_next     = prev_l_reg;
        prev_r_next     = prev_r_reg;
        prod_next       = prod_reg;
        out_left_next   = out_left_reg;
        out_right_next  = out_right_reg;
        last_next       = last_reg;
        in_ready        = 1'b0;

        if (cfg_wen)
        begin
            unique case (cfg_index)
                lir_pkg::CFG_STEP_RATIO: step_ratio_next = cfg_data;
                lir_pkg::CFG_STEREO:     stereo_next     = cfg_data[0];
                lir_pkg::CFG_BYPASS:     bypass_next     = cfg_data[0];
                default:                 ;
            endcase
        end

        unique case (state_reg)
            lir_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cur_l_next = left_sample;
                    cur_r_next = right_sample;
                    priority if (bypass_reg)
                    begin
                        // frame goes straight out as a single result
                        out_left_next  = left_sample;
                        out_right_next = stereo_reg ? right_sample : '0;
                        last_next      = 1'b1;
                        out_valid_next = 1'b1;
                        byp_run_next   = 1'b1;
                        have_prev_next = 1'b1;
                        state_next     = lir_pkg::ST_SEND;
                    end
                    else if (!have_prev_reg)
                    begin
                        // first frame is only stored
                        prev_l_next    = left_sample;
                        prev_r_next    = right_sample;
                        have_prev_next = 1'b1;
                    end
                    else
                    begin
                        byp_run_next = 1'b0;
                        state_next   = lir_pkg::ST_CHECK;
                    end
                end
            end

            lir_pkg::ST_CHECK:
            begin
                if (phase_reg < ONE_FX)
                begin
                    state_next = lir_pkg::ST_MUL_L;
                end
                else
                begin
                    // large step: no result from this frame
                    phase_next  = phase_reg - ONE_FX;
                    prev_l_next = cur_l_reg;
                    prev_r_next = cur_r_reg;
                    state_next  = lir_pkg::ST_IDLE;
                end
            end

            lir_pkg::ST_MUL_L:
            begin
                prod_next  = prod;
                state_next = lir_pkg::ST_MUL_R;
            end

            lir_pkg::ST_MUL_R:
            begin
                out_left_next = lerp;
                prod_next     = prod;
                state_next    = lir_pkg::ST_FIN;
            end

            lir_pkg::ST_FIN:
            begin
                out_right_next = stereo_reg ? lerp : '0;
                phase_next     = phase_sum;
                last_next      = (phase_sum >= ONE_FX);
                out_valid_next = 1'b1;
                state_next     = lir_pkg::ST_SEND;
            end

            lir_pkg::ST_SEND:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (last_reg)
                    begin
                        prev_l_next = cur_l_reg;
                        prev_r_next = cur_r_reg;
                        if (!byp_run_reg)
                        begin
                            phase_next = phase_reg - ONE_FX;
                        end
                        state_next = lir_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = lir_pkg::ST_MUL_L;
                    end
                end
            end

            default:
            begin
                state_next = lir_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lir_pkg::ST_IDLE;
            step_ratio_reg <= STEP_RST;
            stereo_reg     <= 1'b0;
            bypass_reg     <= 1'b0;
            have_prev_reg  <= 1'b0;
            phase_reg      <= '0;
            out_valid_reg  <= 1'b0;
            byp_run_reg    <= 1'b0;
            prev_l_reg     <= '0;
            prev_r_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            step_ratio_reg <= step_ratio_next;
            stereo_reg     <= stereo_next;
            bypass_reg     <= bypass_next;
            have_prev_reg  <= have_prev_next;
            phase_reg      <= phase_next;
            out_valid_reg  <= out_valid_next;
            byp_run_reg    <= byp_run_next;
            prev_l_reg     <= prev_l_next;
            prev_r_reg     <= prev_r_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_l_reg     <= cur_l_next;
        cur_r_reg     <= cur_r_next;
        prod_reg      <= prod_next;
        out_left_reg  <= out_left_next;
        out_right_reg <= out_right_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_left  = out_left_reg;
    assign out_right = out_right_reg;
    assign run_last  = last_reg;

    // no new frame is taken while a result transaction is pending
    a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input accepted while result pending");

    // a result that is not the last leaves the phase below 1.0
    a_phase_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !run_last) |-> (phase_reg < ONE_FX))
        else $error("non-final result with phase at or above 1.0");

    // taking the last result of a frame frees the input side
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && run_last) |=> (in_ready && !out_valid))
        else $error("block not idle after last result");

    // the first stored frame gives no result and marks a frame as seen
    a_first_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !have_prev_reg && !bypass_reg)
        |=> (in_ready && have_prev_reg && !out_valid))
        else $error("first frame handling broken");

endmodule
